### hdl/b64e_pkg.sv
// shared types, constants and the alphabet lookup for the base64 stream encoder
package b64e_pkg;

    // message size bound and derived length limit
    localparam int unsigned MaxMessageBytes = 65536;
    localparam int unsigned LenFieldMax     = 131071;
    localparam int unsigned LenLimitRaw     = ((MaxMessageBytes + 2) / 3) * 4;
    localparam int unsigned LenLimit        = (LenLimitRaw > LenFieldMax) ?
                                              LenFieldMax : LenLimitRaw;

    localparam int unsigned LenW    = 17;
    localparam int unsigned GroupsW = 15;

    localparam logic [LenW-1:0]    LEN_LIMIT  = LenW'(LenLimit);
    localparam logic [GroupsW-1:0] GROUPS_MAX = '1;

    // characters
    localparam logic [7:0] PAD_CHAR     = 8'd61;   // '='
    localparam logic [7:0] CHAR62_RESET = 8'd45;   // '-'
    localparam logic [7:0] CHAR63_RESET = 8'd126;  // '~'

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_CHAR_SIXTY_TWO   = 1'b0,
        CFG_CHAR_SIXTY_THREE = 1'b1
    } cfg_index_t;

    // one finished group of four characters
    typedef struct packed {
        logic [3:0][7:0] chars;      // chars[0] goes out first
        logic            msg_end;
        logic [LenW-1:0] length;
    } group_t;

    // six-bit value to alphabet character
    function automatic logic [7:0] map_six(input logic [5:0] v,
                                           input logic [7:0] c62,
                                           input logic [7:0] c63);
        logic [7:0] r;
        case (v) inside
            [6'd0:6'd25]:  r = 8'd65 + {2'b00, v};
            [6'd26:6'd51]: r = 8'd97 + ({2'b00, v} - 8'd26);
            [6'd52:6'd61]: r = 8'd48 + ({2'b00, v} - 8'd52);
            6'd62:         r = c62;
            default:       r = c63;
        endcase
        return r;
    endfunction

endpackage

### hdl/base64_stream_encoder.sv
// top level of the base64 stream encoder
// latency: a group's first character is valid the cycle after the byte that completes it
// throughput: one character per cycle out while out_ready is high; the output register holds one group, so
//   input bytes wait while that register holds a group whose last character has not yet been taken
// every byte, whether or not it completes a group, is taken only while the output register can load
// reset clears pending bytes, group count and the output register's valid flag and index; alphabet tail goes to '-' '~'
module base64_stream_encoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [0:0]                  cfg_index,
    input  logic [7:0]                  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  data_byte,
    input  logic                        last_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_char,
    output logic                        group_end,
    output logic                        message_end,
    output logic [b64e_pkg::LenW-1:0]   encoded_length
);

    logic [7:0]                     c62_reg;
    logic [7:0]                     c63_reg;
    logic [15:0]                    pend_reg, pend_next;
    logic [1:0]                     cnt_reg, cnt_next;
    logic [b64e_pkg::GroupsW-1:0]   groups_reg, groups_next;

    logic                           accept;
    logic                           complete;
    logic                           load;
    logic                           can_load;
    logic [1:0]                     cnt_new;
    logic [23:0]                    word;
    logic [b64e_pkg::LenW:0]        len_full;
    b64e_pkg::group_t               grp;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c62_reg <= b64e_pkg::CHAR62_RESET;
            c63_reg <= b64e_pkg::CHAR63_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                b64e_pkg::CFG_CHAR_SIXTY_TWO:   c62_reg <= cfg_data;
                b64e_pkg::CFG_CHAR_SIXTY_THREE: c63_reg <= cfg_data;
                default:                        c63_reg <= cfg_data;
            endcase
        end
    end

    // input request
    assign in_ready = can_load;
    assign accept   = in_valid && in_ready;

    // assemble the group left-aligned in 24 bits
    always_comb
    begin
        case (cnt_reg)
            2'd0:    word = {data_byte, 16'h0000};
            2'd1:    word = {pend_reg[15:8], data_byte, 8'h00};
            default: word = {pend_reg, data_byte};
        endcase
    end

    assign cnt_new  = (cnt_reg == 2'd0) ? 2'd1 : ((cnt_reg == 2'd1) ? 2'd2 : 2'd3);
    assign complete = (cnt_new == 2'd3) || last_byte;
    assign load     = accept && complete;

    // length of the whole message, saturating
    assign len_full = {1'b0, groups_reg, 2'b00} + 18'd4;

    // four characters of the group
    always_comb
    begin
        grp.chars[0] = b64e_pkg::map_six(word[23:18], c62_reg, c63_reg);
        grp.chars[1] = b64e_pkg::map_six(word[17:12], c62_reg, c63_reg);
        grp.chars[2] = (cnt_new >= 2'd2) ?
                       b64e_pkg::map_six(word[11:6], c62_reg, c63_reg) : b64e_pkg::PAD_CHAR;
        grp.chars[3] = (cnt_new == 2'd3) ?
                       b64e_pkg::map_six(word[5:0], c62_reg, c63_reg) : b64e_pkg::PAD_CHAR;
        grp.msg_end  = last_byte;
        grp.length   = (len_full > {1'b0, b64e_pkg::LEN_LIMIT}) ?
                       b64e_pkg::LEN_LIMIT : len_full[b64e_pkg::LenW-1:0];
    end

    // pending bytes and group count
    always_comb
    begin
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        groups_next = groups_reg;
        if (accept)
        begin
            if (complete)
            begin
                pend_next = 16'h0000;
                cnt_next  = 2'd0;
                if (last_byte)
                begin
                    groups_next = '0;
                end
                else if (groups_reg != b64e_pkg::GROUPS_MAX)
                begin
                    groups_next = groups_reg + 1'b1;
                end
            end
            else
            begin
                pend_next = word[23:8];
                cnt_next  = cnt_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= 16'h0000;
            cnt_reg    <= 2'd0;
            groups_reg <= '0;
        end
        else
        begin
            pend_reg   <= pend_next;
            cnt_reg    <= cnt_next;
            groups_reg <= groups_next;
        end
    end

    // output group register
    b64e_out_buf u_out_buf (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .grp            (grp),
        .can_load       (can_load),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_char       (out_char),
        .group_end      (group_end),
        .message_end    (message_end),
        .encoded_length (encoded_length)
    );

endmodule

### hdl/b64e_out_buf.sv
// output group register that sends four characters one per request
module b64e_out_buf (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  b64e_pkg::group_t            grp,
    output logic                        can_load,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_char,
    output logic                        group_end,
    output logic                        message_end,
    output logic [b64e_pkg::LenW-1:0]   encoded_length
);

    logic             valid_reg, valid_next;
    logic [1:0]       idx_reg, idx_next;
    b64e_pkg::group_t grp_reg;
    logic             pop;
    logic             pop_last;

    // handshake on the output side
    assign pop      = valid_reg && out_ready;
    assign pop_last = pop && (idx_reg == 2'd3);
    assign can_load = !valid_reg || pop_last;

    // occupancy and character index
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (pop)
        begin
            idx_next = idx_reg + 2'd1;
        end
        if (pop_last)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // group payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= grp;
        end
    end

    // current character
    assign out_valid      = valid_reg;
    assign out_char       = grp_reg.chars[idx_reg];
    assign group_end      = (idx_reg == 2'd3);
    assign message_end    = (idx_reg == 2'd3) && grp_reg.msg_end;
    assign encoded_length = message_end ? grp_reg.length : '0;

endmodule

### dv/tb_base64_stream_encoder.sv
// self-checking testbench for the base64 stream encoder
`timescale 1ns / 100ps

module tb_base64_stream_encoder;

    localparam int unsigned MSG_BYTES_MAX = b64e_pkg::MaxMessageBytes;
    localparam int unsigned LEN_RAW_CAP   = ((MSG_BYTES_MAX + 2) / 3) * 4;
    localparam int unsigned LEN_CAP       = (LEN_RAW_CAP > 131071) ? 131071 : LEN_RAW_CAP;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned ERR_SHOWN     = 10;
    localparam int unsigned PHASE_BYTES   = 80;

    // byte content of a generated message
    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_SIXTY_TWO
    } byte_fill_t;

    // one encoded character as it should leave the block
    typedef struct {
        logic [7:0]                ch;
        logic                      grp_end;
        logic                      msg_end;
        logic [b64e_pkg::LenW-1:0] len;
    } b64_char_t;

    // predicts the character stream and compares it with what the block sends
    class base64_char_tracker;
        logic [7:0]   c62;
        logic [7:0]   c63;
        logic [15:0]  held_bytes;
        int unsigned  held_cnt;
        logic [14:0]  group_cnt;
        b64_char_t    due_chars[$];
        int unsigned  mismatches;

        function new();
            c62        = b64e_pkg::CHAR62_RESET;
            c63        = b64e_pkg::CHAR63_RESET;
            held_bytes = '0;
            held_cnt   = 0;
            group_cnt  = '0;
            mismatches = 0;
        endfunction

        function void set_char(input b64e_pkg::cfg_index_t idx, input logic [7:0] v);
            if (idx == b64e_pkg::CFG_CHAR_SIXTY_TWO)
                c62 = v;
            else
                c63 = v;
        endfunction

        // alphabet: A-Z, a-z, 0-9, then the two programmable characters
        function logic [7:0] encode_six(input logic [5:0] v);
            if (v < 6'd26)
                return 8'd65 + 8'(v);
            else if (v < 6'd52)
                return 8'd97 + 8'(v) - 8'd26;
            else if (v < 6'd62)
                return 8'd48 + 8'(v) - 8'd52;
            else if (v == 6'd62)
                return c62;
            else
                return c63;
        endfunction

        // accepted input request: hold the byte or emit a group
        function void note_byte(input logic [7:0] b, input logic is_last);
            logic [23:0]  grp;
            logic [7:0]   chars [4];
            int unsigned  n;
            int unsigned  len;
            b64_char_t    c;
            n   = held_cnt;
            grp = {held_bytes, 8'h00} | (24'(b) << (8 * (2 - n)));
            n   = n + 1;
            if (n < 3 && !is_last)
            begin
                held_bytes = grp[23:8];
                held_cnt   = n;
                return;
            end
            chars[0] = encode_six(grp[23:18]);
            chars[1] = encode_six(grp[17:12]);
            chars[2] = (n >= 2) ? encode_six(grp[11:6]) : b64e_pkg::PAD_CHAR;
            chars[3] = (n >= 3) ? encode_six(grp[5:0]) : b64e_pkg::PAD_CHAR;
            for (int k = 0; k < 4; k++)
            begin
                c.ch      = chars[k];
                c.grp_end = (k == 3);
                c.msg_end = is_last && (k == 3);
                c.len     = '0;
                if (c.msg_end)
                begin
                    len   = (int'(group_cnt) + 1) * 4;
                    c.len = b64e_pkg::LenW'((len > LEN_CAP) ? LEN_CAP : len);
                end
                due_chars.push_back(c);
            end
            // group count clears per message and sticks at its top value
            if (is_last)
                group_cnt = '0;
            else if (group_cnt != '1)
                group_cnt = group_cnt + 1'b1;
            held_bytes = '0;
            held_cnt   = 0;
        endfunction

        // accepted output request against the oldest expected character
        function void check_char(input logic [7:0] ch, input logic grp_end,
                                 input logic msg_end,
                                 input logic [b64e_pkg::LenW-1:0] len);
            b64_char_t c;
            if (due_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= ERR_SHOWN)
                    $display("%0t: unexpected char %h group_end %b message_end %b len %0d",
                             $realtime, ch, grp_end, msg_end, len);
                return;
            end
            c = due_chars.pop_front();
            if (ch !== c.ch || grp_end !== c.grp_end || msg_end !== c.msg_end
                || len !== c.len)
            begin
                mismatches++;
                if (mismatches <= ERR_SHOWN)
                    $display("%0t: char exp %h/%b/%b/%0d got %h/%b/%b/%0d", $realtime,
                             c.ch, c.grp_end, c.msg_end, c.len, ch, grp_end, msg_end, len);
            end
        endfunction

        function int unsigned outstanding();
            return due_chars.size();
        endfunction
    endclass

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      cfg_valid   = 1'b0;
    logic                      cfg_ready;
    logic [0:0]                cfg_index   = '0;
    logic [7:0]                cfg_data    = '0;
    logic                      in_valid    = 1'b0;
    logic                      in_ready;
    logic [7:0]                data_byte   = '0;
    logic                      last_byte   = 1'b0;
    logic                      out_valid;
    logic                      out_ready   = 1'b0;
    logic [7:0]                out_char;
    logic                      group_end;
    logic                      message_end;
    logic [b64e_pkg::LenW-1:0] encoded_length;

    int unsigned         send_idle_pct  = 0;
    int unsigned         recv_stall_pct = 0;
    base64_char_tracker  tracker;

    base64_stream_encoder i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_char       (out_char),
        .group_end      (group_end),
        .message_end    (message_end),
        .encoded_length (encoded_length)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("tb_base64_stream_encoder failed");
        $finish;
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_char(out_char, group_end, message_end, encoded_length);
    end

    // one input request, with an optional random gap ahead of it
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_byte(b, is_last);
    endtask

    // whole message, last byte flagged
    task automatic send_msg(input int unsigned len, input byte_fill_t fill);
        logic [7:0] b;
        for (int unsigned i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ZERO:      b = 8'h00;
                FILL_ONES:      b = 8'hff;
                // 0xfb 0xef 0xbe encodes to four sixty-twos
                FILL_SIXTY_TWO: b = (i % 3 == 0) ? 8'hfb : (i % 3 == 1) ? 8'hef : 8'hbe;
                default:        b = 8'($urandom_range(255, 0));
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    // let every expected character drain, then a few more cycles
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // both alphabet registers, valid held across the two requests
    task automatic write_alphabet(input logic [7:0] v62, input logic [7:0] v63);
        b64e_pkg::cfg_index_t idx;
        for (int i = 0; i < 2; i++)
        begin
            idx       = (i == 0) ? b64e_pkg::CFG_CHAR_SIXTY_TWO
                                 : b64e_pkg::CFG_CHAR_SIXTY_THREE;
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= (i == 0) ? v62 : v63;
            do
                @(posedge clk);
            while (!cfg_ready);
            tracker.set_char(idx, (i == 0) ? v62 : v63);
        end
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        int unsigned sent;
        int unsigned len;
        tracker = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: padding of one and two bytes, full final group, edge values
        send_msg(1, FILL_RANDOM);
        send_msg(2, FILL_RANDOM);
        send_msg(3, FILL_RANDOM);
        send_msg(3, FILL_ZERO);
        send_msg(3, FILL_ONES);
        send_msg(3, FILL_SIXTY_TWO);
        send_msg(5, FILL_SIXTY_TWO);
        wait_idle();

        // alphabet tail at its extremes
        write_alphabet(8'h00, 8'hff);
        send_msg(3, FILL_SIXTY_TWO);
        send_msg(1, FILL_ONES);
        wait_idle();
        write_alphabet(8'hff, 8'h00);
        send_msg(3, FILL_SIXTY_TWO);
        send_msg(1, FILL_ONES);
        wait_idle();

        // random messages under each idling mix
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            write_alphabet(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                len = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 11)
                                                  : $urandom_range(10, 1);
                send_msg(len, FILL_RANDOM);
                sent += len;
            end
            wait_idle();
        end

        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("tb_base64_stream_encoder passed");
        else
            $display("tb_base64_stream_encoder failed");
        $finish;
    end

endmodule
